[sv/skt_pkg.sv]
package skt_pkg;

    localparam int KIND_W    = 3;
    localparam int KEY_W     = 16;
    localparam int TAG_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 4;
    localparam int CNT_OUT_W = 5;
    localparam int DEPTH_DEF = 16;

    // Command kinds.
    localparam logic [KIND_W-1:0] K_LOOKUP = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] K_UPDATE = 3'd2;
    localparam logic [KIND_W-1:0] K_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // Cell operations.
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_UPD  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
        logic              done_in;
        logic [TAG_W-1:0]  tag_in;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [POS_W-1:0]     position;
        logic                 done_out;
        logic [TAG_W-1:0]     tag_out;
        logic [CNT_OUT_W-1:0] count_out;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             done;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        logic match;
        logic lt;
        logic open;
        logic ge;
        logic first;
        logic ins_here;
    } cell_flags_t;

endpackage

[sv/skt_cell.sv]
module skt_cell (
    input  logic                clk,
    input  logic [1:0]          op,
    input  skt_pkg::cmd_t       cmd,
    input  logic                valid,
    input  skt_pkg::entry_t     left_entry,
    input  logic                left_lt,
    input  logic                left_open,
    input  skt_pkg::entry_t     right_entry,
    output skt_pkg::entry_t     entry,
    output skt_pkg::cell_flags_t flags
);
    import skt_pkg::*;

    entry_t e_reg;
    entry_t e_next;

    // An open cell is empty or holds a key above the command key; open cells
    // form a suffix of the row because the keys are kept sorted.
    always_comb
    begin
        flags.match    = valid && (e_reg.key == cmd.key);
        flags.lt       = valid && (e_reg.key < cmd.key);
        flags.open     = !(valid && (e_reg.key <= cmd.key));
        flags.ge       = valid && !(e_reg.key < cmd.key);
        flags.first    = left_lt && flags.match;
        flags.ins_here = !left_open && flags.open;
    end

    always_comb
    begin
        e_next = e_reg;
        case (op)
            OP_INS:
            begin
                if (left_open)
                begin
                    e_next = left_entry;
                end
                else if (flags.open)
                begin
                    e_next.key  = cmd.key;
                    e_next.done = cmd.done_in;
                    e_next.tag  = cmd.tag_in;
                end
            end
            OP_DEL:
            begin
                if (flags.ge)
                begin
                    e_next = right_entry;
                end
            end
            OP_UPD:
            begin
                if (flags.first)
                begin
                    e_next.done = cmd.done_in;
                end
            end
            default:
            begin
                e_next = e_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
    end

    assign entry = e_reg;

endmodule

[sv/sorted_key_table.sv]
// Channel   Handshake                  Word
// command   start in, busy out         cmd (kind, key, done_in, tag_in)
// result    result_valid out (strobe)  result (status, position, done_out, tag_out, count_out)
//
// A command is taken on an edge with start high and busy low; the row of cells
// works on it in the next cycle and the result strobe is registered from that
// work. A delete that finds its key keeps busy high while it removes one copy
// per pass, one cell shift per entry removed, and registers the strobe from a
// final compare. A new command may be taken while a result shows.
// Reset empties the table. The receiver cannot stall results.
module sorted_key_table #(
    parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  skt_pkg::cmd_t cmd,
    output logic          result_valid,
    output skt_pkg::rsp_t result
);
    import skt_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DEL  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    cmd_t             cmd_reg;
    rsp_t             rsp_reg, rsp_next;
    logic             rv_reg, rv_next;
    logic [1:0]       cell_op;

    entry_t      ent [DEPTH];
    cell_flags_t flg [DEPTH];
    logic [DEPTH-1:0] valid;

    logic             any_match;
    logic [IDX_W-1:0] hit_idx;
    logic             hit_done;
    logic [TAG_W-1:0] hit_tag;
    logic [IDX_W-1:0] ins_idx;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_lt;
            logic   left_open;

            assign valid[g] = (CNT_W'(g) < count_reg);

            if (g == 0)
            begin : g_first
                assign left_e    = ent[g];
                assign left_lt   = 1'b1;
                assign left_open = 1'b0;
            end
            else
            begin : g_mid
                assign left_e    = ent[g-1];
                assign left_lt   = flg[g-1].lt;
                assign left_open = flg[g-1].open;
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign right_e = ent[g];
            end
            else
            begin : g_inner
                assign right_e = ent[g+1];
            end

            skt_cell u_cell (
                .clk         (clk),
                .op          (cell_op),
                .cmd         (cmd_reg),
                .valid       (valid[g]),
                .left_entry  (left_e),
                .left_lt     (left_lt),
                .left_open   (left_open),
                .right_entry (right_e),
                .entry       (ent[g]),
                .flags       (flg[g])
            );
        end
    endgenerate

    // At most one cell flags the first match and one the insert slot.
    always_comb
    begin
        any_match = 1'b0;
        hit_idx   = '0;
        hit_done  = 1'b0;
        hit_tag   = '0;
        ins_idx   = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            any_match = any_match | flg[i].match;
            if (flg[i].first)
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_done = hit_done | ent[i].done;
                hit_tag  = hit_tag | ent[i].tag;
            end
            if (flg[i].ins_here)
            begin
                ins_idx = ins_idx | IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rsp_next   = rsp_reg;
        rv_next    = 1'b0;
        cell_op    = OP_HOLD;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                rv_next    = 1'b1;
                rsp_next   = '0;
                case (cmd_reg.kind) inside
                    K_LOOKUP, K_UPDATE:
                    begin
                        if (any_match)
                        begin
                            rsp_next.position = POS_W'(hit_idx);
                            rsp_next.tag_out  = hit_tag;
                            if (cmd_reg.kind == K_UPDATE)
                            begin
                                cell_op           = OP_UPD;
                                rsp_next.done_out = cmd_reg.done_in;
                            end
                            else
                            begin
                                rsp_next.done_out = hit_done;
                            end
                        end
                        else
                        begin
                            rsp_next.status = ST_NOTFOUND;
                        end
                    end
                    K_INSERT:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            cell_op           = OP_INS;
                            count_next        = count_reg + 1'b1;
                            rsp_next.position = POS_W'(ins_idx);
                            rsp_next.done_out = cmd_reg.done_in;
                            rsp_next.tag_out  = cmd_reg.tag_in;
                        end
                    end
                    K_DELETE:
                    begin
                        if (any_match)
                        begin
                            cell_op           = OP_DEL;
                            count_next        = count_reg - 1'b1;
                            rsp_next.position = POS_W'(hit_idx);
                            rsp_next.done_out = hit_done;
                            rsp_next.tag_out  = hit_tag;
                            rv_next           = 1'b0;
                            state_next        = S_DEL;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOTFOUND;
                        end
                    end
                    K_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                rsp_next.count_out = CNT_OUT_W'(count_next);
            end
            S_DEL:
            begin
                // Each pass removes one more copy of the key.
                if (any_match)
                begin
                    cell_op    = OP_DEL;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next         = S_IDLE;
                    rv_next            = 1'b1;
                    rsp_next.count_out = CNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result       = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> state_reg == S_IDLE)
        else $error("result strobe while a command is still in work");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg == S_EXEC)
        else $error("accepted command did not enter execution");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && rsp_reg.status == ST_FULL |-> count_reg == CNT_W'(DEPTH))
        else $error("full status with room left in the table");

    a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DEL && any_match |=> count_reg == $past(count_reg) - 1'b1)
        else $error("delete pass did not remove an entry");

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
    import skt_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RAND_WORDS   = 1000;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 10;
    localparam int POOL_SIZE    = 6;

    // Kinds the block does not define; it must answer them and change nothing.
    localparam logic [KIND_W-1:0] K_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] K_UNUSED_HI = 3'd7;

    localparam rsp_t NO_RSP = '0;

    typedef struct {
        cmd_t c;
        int   reps;
        bit   fixed;
        rsp_t want;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic result_valid;
    rsp_t result;

    // Mirror of the table contents.
    logic [KEY_W-1:0] mirror_keys [DEPTH];
    logic             mirror_done [DEPTH];
    logic [TAG_W-1:0] mirror_tags [DEPTH];
    int               mirror_count;

    rsp_t        pending_rsp [$];
    script_row_t script [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int mismatch_count;
    int cycle_count;
    int burst_left;

    sorted_key_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rsp_t mirror_exec(cmd_t c);
        rsp_t r;
        int   i;
        int   w;
        int   idx;
        r = '0;
        r.status = ST_OK;
        case (c.kind)
            K_LOOKUP, K_UPDATE:
            begin
                idx = -1;
                for (i = 0; i < mirror_count; i++)
                    if (idx < 0 && mirror_keys[i] == c.key)
                        idx = i;
                if (idx < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    if (c.kind == K_UPDATE)
                        mirror_done[idx] = c.done_in;
                    r.position = POS_W'(idx);
                    r.done_out = mirror_done[idx];
                    r.tag_out  = mirror_tags[idx];
                end
            end
            K_INSERT:
            begin
                if (mirror_count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // New entry goes after every entry with an equal key.
                    i = mirror_count;
                    while (i > 0 && mirror_keys[i-1] > c.key)
                    begin
                        mirror_keys[i] = mirror_keys[i-1];
                        mirror_done[i] = mirror_done[i-1];
                        mirror_tags[i] = mirror_tags[i-1];
                        i--;
                    end
                    mirror_keys[i] = c.key;
                    mirror_done[i] = c.done_in;
                    mirror_tags[i] = c.tag_in;
                    mirror_count++;
                    r.position = POS_W'(i);
                    r.done_out = c.done_in;
                    r.tag_out  = c.tag_in;
                end
            end
            K_DELETE:
            begin
                idx = -1;
                w = 0;
                for (i = 0; i < mirror_count; i++)
                begin
                    if (mirror_keys[i] == c.key)
                    begin
                        if (idx < 0)
                        begin
                            idx = i;
                            r.position = POS_W'(i);
                            r.done_out = mirror_done[i];
                            r.tag_out  = mirror_tags[i];
                        end
                    end
                    else
                    begin
                        mirror_keys[w] = mirror_keys[i];
                        mirror_done[w] = mirror_done[i];
                        mirror_tags[w] = mirror_tags[i];
                        w++;
                    end
                end
                mirror_count = w;
                if (idx < 0)
                    r.status = ST_NOTFOUND;
            end
            K_CLEAR:
                mirror_count = 0;
            default:
                ;
        endcase
        r.count_out = CNT_OUT_W'(mirror_count);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch (%s): expected st=%0d pos=%0d done=%0b tag=%h cnt=%0d, got st=%0d pos=%0d done=%0b tag=%h cnt=%0d",
                     $realtime, what,
                     want.status, want.position, want.done_out, want.tag_out, want.count_out,
                     got.status, got.position, got.done_out, got.tag_out, got.count_out);
    endtask

    // Hands one word to the block, inserting sender gaps between bursts, and
    // records the expected result once the word is taken.
    task automatic send_word(input cmd_t c, input bit fixed, input rsp_t want);
        rsp_t guess;
        int   gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                burst_left = $urandom_range(40, 100);
                gap = 0;
            end
            else
            begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(0, 8);
            end
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        guess = mirror_exec(c);
        pending_rsp.push_back(fixed ? want : guess);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 80)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return KEY_W'($urandom_range(0, 65535));
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && result_valid)
        begin
            if (pending_rsp.size() == 0)
                flag_mismatch("result with no command outstanding", NO_RSP, result);
            else
            begin
                want = pending_rsp.pop_front();
                if (result.status !== want.status)
                    flag_mismatch("status", want, result);
                else if (result.position !== want.position)
                    flag_mismatch("position", want, result);
                else if (result.done_out !== want.done_out)
                    flag_mismatch("done_out", want, result);
                else if (result.tag_out !== want.tag_out)
                    flag_mismatch("tag_out", want, result);
                else if (result.count_out !== want.count_out)
                    flag_mismatch("count_out", want, result);
            end
        end
    end

    initial
    begin
        script_row_t row;
        cmd_t        c;
        int          n;
        int          r;
        int          roll;
        int          ins_weight;
        int          k;

        mismatch_count = 0;
        cycle_count    = 0;
        burst_left     = 0;
        mirror_count   = 0;
        ins_weight     = 35;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd   <= '0;

        // Empty table first, then a full table of the two end keys and one duplicated key.
        script.push_back(script_row_t'{cmd_t'{K_LOOKUP, 16'h1234, 1'b0, 64'h0}, 1, 1'b1,
                                       rsp_t'{ST_NOTFOUND, 4'd0, 1'b0, 64'h0, 5'd0}});
        script.push_back(script_row_t'{cmd_t'{K_DELETE, 16'h0000, 1'b0, 64'h0}, 1, 1'b1,
                                       rsp_t'{ST_NOTFOUND, 4'd0, 1'b0, 64'h0, 5'd0}});
        script.push_back(script_row_t'{cmd_t'{K_UNUSED_LO, 16'hFFFF, 1'b1, '1}, 1, 1'b1,
                                       rsp_t'{ST_OK, 4'd0, 1'b0, 64'h0, 5'd0}});
        script.push_back(script_row_t'{cmd_t'{K_INSERT, 16'hFFFF, 1'b1, '1}, 1, 1'b1,
                                       rsp_t'{ST_OK, 4'd0, 1'b1, '1, 5'd1}});
        script.push_back(script_row_t'{cmd_t'{K_INSERT, 16'h0000, 1'b0, 64'h0}, 1, 1'b1,
                                       rsp_t'{ST_OK, 4'd0, 1'b0, 64'h0, 5'd2}});
        script.push_back(script_row_t'{cmd_t'{K_INSERT, 16'h8000, 1'b0,
                                              64'h0123_4567_89AB_CDEF}, 14, 1'b0, NO_RSP});
        script.push_back(script_row_t'{cmd_t'{K_INSERT, 16'h1234, 1'b1, '1}, 1, 1'b1,
                                       rsp_t'{ST_FULL, 4'd0, 1'b0, 64'h0, 5'd16}});
        script.push_back(script_row_t'{cmd_t'{K_LOOKUP, 16'h8000, 1'b0, 64'h0}, 1, 1'b0,
                                       NO_RSP});
        script.push_back(script_row_t'{cmd_t'{K_UPDATE, 16'h8000, 1'b1, 64'h0}, 1, 1'b0,
                                       NO_RSP});
        script.push_back(script_row_t'{cmd_t'{K_UPDATE, 16'h1111, 1'b1, 64'h0}, 1, 1'b1,
                                       rsp_t'{ST_NOTFOUND, 4'd0, 1'b0, 64'h0, 5'd16}});
        script.push_back(script_row_t'{cmd_t'{K_UNUSED_HI, 16'h8000, 1'b1, '1}, 1, 1'b1,
                                       rsp_t'{ST_OK, 4'd0, 1'b0, 64'h0, 5'd16}});
        script.push_back(script_row_t'{cmd_t'{K_DELETE, 16'h8000, 1'b0, 64'h0}, 1, 1'b0,
                                       NO_RSP});
        script.push_back(script_row_t'{cmd_t'{K_LOOKUP, 16'hFFFF, 1'b0, 64'h0}, 1, 1'b0,
                                       NO_RSP});
        script.push_back(script_row_t'{cmd_t'{K_CLEAR, 16'h0000, 1'b0, 64'h0}, 1, 1'b1,
                                       rsp_t'{ST_OK, 4'd0, 1'b0, 64'h0, 5'd0}});
        script.push_back(script_row_t'{cmd_t'{K_LOOKUP, 16'h0000, 1'b0, 64'h0}, 1, 1'b1,
                                       rsp_t'{ST_NOTFOUND, 4'd0, 1'b0, 64'h0, 5'd0}});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            row = script[i];
            for (r = 0; r < row.reps; r++)
            begin
                c = row.c;
                c.tag_in  = c.tag_in + TAG_W'(r);
                c.done_in = c.done_in ^ r[0];
                send_word(c, row.fixed, row.want);
            end
        end

        for (n = 0; n < RAND_WORDS; n++)
        begin
            // Each phase uses a fresh small key set so that hits, duplicates
            // and a full table all come up often.
            if (n % 100 == 0)
            begin
                ins_weight = $urandom_range(20, 60);
                key_pool[0] = 16'h0000;
                key_pool[1] = 16'hFFFF;
                for (k = 2; k < POOL_SIZE; k++)
                    key_pool[k] = KEY_W'($urandom_range(0, 65535));
            end
            c.key     = pick_key();
            c.done_in = 1'($urandom_range(0, 1));
            c.tag_in  = {$urandom, $urandom};
            roll = $urandom_range(0, 99);
            if (roll < 3)
                c.kind = KIND_W'($urandom_range(K_UNUSED_LO, K_UNUSED_HI));
            else if (roll < 5)
                c.kind = K_CLEAR;
            else if (roll < 5 + ins_weight)
                c.kind = K_INSERT;
            else
            begin
                case ($urandom_range(0, 2))
                    0: c.kind = K_LOOKUP;
                    1: c.kind = K_UPDATE;
                    default: c.kind = K_DELETE;
                endcase
            end
            send_word(c, 1'b0, NO_RSP);
        end
        start <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sorted_key_table.f]
sv/skt_pkg.sv
sv/skt_cell.sv
sv/sorted_key_table.sv
bench/tb.sv
